// File: rtl/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
// No dependencies; every other file except swm_ram refers to this package by scoped names.
package swm_pkg;

	// Default sizes of the sample store.
	localparam int unsigned WINDOW_MAX_DEF = 64;
	localparam int unsigned DATA_WIDTH_DEF = 16;

	// Fixed widths of the ports.
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned WSIZE_W  = 7;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register map: index is the byte address divided by four.
	localparam int unsigned REG_IDX_W = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;
	localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_sample;
		logic evict;
		logic scan;
		logic write;
		logic load_out;
	} swm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic emit;
		logic gone_is_max;
		logic fill_one;
		logic scan_last;
	} swm_status_t;

endpackage

// File: rtl/sliding_window_maximum.sv
// Top level of the sliding window maximum: APB register decode and the
// controller, datapath and sample memory. Depends on swm_pkg, swm_ram,
// swm_datapath and swm_ctrl.
//
//   Channel   Handshake             Payload        Direction
//   input     in_valid / in_ready   sample         into block
//   output    out_valid / out_ready window_max     out of block
//   config    psel / penable        pwdata, paddr  APB write/read, pready = 1
//
// An item passes through IDLE and WRITE while the window fills, through IDLE,
// CHECK and WRITE once it is full, and through CHECK, SCAN and WRITE when the
// evicted sample was the maximum: the remaining samples are read back one per
// cycle through the single registered read port of the sample memory.
// After reset the block is ready at once; the memory needs no clearing.
// A new item is taken while a result waits; the block stalls only when a
// second result is ready before the first one has been taken.
module sliding_window_maximum #(
	parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
	parameter int unsigned DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swm_pkg::SAMPLE_W-1:0]      sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [swm_pkg::SAMPLE_W-1:0]      window_max
);

	localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	swm_pkg::swm_cmd_t           cmd;
	swm_pkg::swm_status_t        status;
	logic                        reg_hit;
	logic                        cfg_we;
	logic [swm_pkg::WSIZE_W-1:0] window_size;
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [DATA_WIDTH-1:0]       ram_wdata;
	logic [IDX_W-1:0]            ram_raddr;
	logic [DATA_WIDTH-1:0]       ram_rdata;

	// Register decode: one register, window_size, at byte address zero.
	assign reg_hit = (paddr[swm_pkg::APB_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE);
	assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? swm_pkg::APB_DATA_W'(window_size) : '0;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	swm_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[swm_pkg::WSIZE_W-1:0]),
		.sample      (sample),
		.cmd         (cmd),
		.status      (status),
		.window_size (window_size),
		.window_max  (window_max),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	swm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (WINDOW_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// File: rtl/swm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module swm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/swm_datapath.sv
// Datapath of the sliding window maximum: window pointers, running maximum,
// rescan counters and the result register. Depends on swm_pkg.
module swm_datapath #(
	parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
	parameter int unsigned DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF,
	localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swm_pkg::WSIZE_W-1:0]    cfg_wdata,
	input  logic [swm_pkg::SAMPLE_W-1:0]   sample,
	input  swm_pkg::swm_cmd_t              cmd,
	output swm_pkg::swm_status_t           status,
	output logic [swm_pkg::WSIZE_W-1:0]    window_size,
	output logic [swm_pkg::SAMPLE_W-1:0]   window_max,
	output logic                           ram_we,
	output logic [IDX_W-1:0]               ram_waddr,
	output logic [DATA_WIDTH-1:0]          ram_wdata,
	output logic [IDX_W-1:0]               ram_raddr,
	input  logic [DATA_WIDTH-1:0]          ram_rdata
);

	localparam int unsigned FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int unsigned SUM_W  = FILL_W + 1;

	logic [swm_pkg::WSIZE_W-1:0] window_size_q;
	logic [IDX_W-1:0]            oldest_q;
	logic [FILL_W-1:0]           fill_q;
	logic [DATA_WIDTH-1:0]       max_q;
	logic [IDX_W-1:0]            scan_ptr_q;
	logic [FILL_W-1:0]           remain_q;
	logic                        pend_q;
	logic [DATA_WIDTH-1:0]       sample_q;
	logic [swm_pkg::SAMPLE_W-1:0] window_max_q;

	logic [FILL_W-1:0]     k_eff;
	logic [IDX_W-1:0]      oldest_nx;
	logic [FILL_W-1:0]     fill_inc;
	logic [FILL_W-1:0]     fill_dec;
	logic [SUM_W-1:0]      wsum;
	logic [SUM_W-1:0]      wsum_wrap;
	logic [DATA_WIDTH-1:0] max_up;
	logic [31:0]           sample_wide;
	logic [31:0]           max_wide;

	// Advance a ring position by one, wrapping at the store depth.
	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W:0] nx;
		logic [IDX_W:0] nx_wrap;
		nx      = {1'b0, p} + (IDX_W+1)'(1);
		nx_wrap = nx - (IDX_W+1)'(WINDOW_MAX);
		if (nx >= (IDX_W+1)'(WINDOW_MAX)) begin
			return nx_wrap[IDX_W-1:0];
		end
		return nx[IDX_W-1:0];
	endfunction

	// Effective window length: zero acts as one, large values saturate.
	always_comb begin
		if (window_size_q == '0) begin
			k_eff = FILL_W'(1);
		end else if (32'(window_size_q) > 32'(WINDOW_MAX)) begin
			k_eff = FILL_W'(WINDOW_MAX);
		end else begin
			k_eff = FILL_W'(window_size_q);
		end
	end

	// Pointer arithmetic for eviction and for the slot of the new sample.
	always_comb begin
		oldest_nx = ring_inc(oldest_q);
		fill_inc  = fill_q + FILL_W'(1);
		fill_dec  = fill_q - FILL_W'(1);
		wsum      = SUM_W'(oldest_q) + SUM_W'(fill_q);
		wsum_wrap = wsum - SUM_W'(WINDOW_MAX);
		if (wsum >= SUM_W'(WINDOW_MAX)) begin
			ram_waddr = IDX_W'(wsum_wrap);
		end else begin
			ram_waddr = IDX_W'(wsum);
		end
		max_up = (sample_q > max_q) ? sample_q : max_q;
	end

	// Input sample cut or extended to the stored width, result to port width.
	assign sample_wide = 32'(sample);
	assign max_wide    = 32'(max_up);

	// Status toward the controller.
	always_comb begin
		status.full        = (fill_q >= k_eff);
		status.emit        = (fill_inc == k_eff);
		status.gone_is_max = (ram_rdata == max_q);
		status.fill_one    = (fill_q == FILL_W'(1));
		status.scan_last   = (remain_q == '0);
	end

	// Memory ports: the oldest entry is read by default, rescan reads otherwise.
	assign ram_raddr = cmd.scan ? scan_ptr_q : oldest_q;
	assign ram_we    = cmd.write;
	assign ram_wdata = sample_q;

	// Window state, running maximum and rescan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swm_pkg::WSIZE_RESET;
			oldest_q      <= '0;
			fill_q        <= '0;
			max_q         <= '0;
			scan_ptr_q    <= '0;
			remain_q      <= '0;
			pend_q        <= 1'b0;
		end else if (cfg_we) begin
			window_size_q <= cfg_wdata;
			oldest_q      <= '0;
			fill_q        <= '0;
			max_q         <= '0;
			pend_q        <= 1'b0;
		end else begin
			if (cmd.evict) begin
				oldest_q <= oldest_nx;
				fill_q   <= fill_dec;
				if (status.gone_is_max) begin
					max_q      <= '0;
					scan_ptr_q <= oldest_nx;
					remain_q   <= fill_dec;
					pend_q     <= 1'b0;
				end
			end
			if (cmd.scan) begin
				if (remain_q != '0) begin
					scan_ptr_q <= ring_inc(scan_ptr_q);
					remain_q   <= remain_q - FILL_W'(1);
					pend_q     <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
				if (pend_q && (ram_rdata > max_q)) begin
					max_q <= ram_rdata;
				end
			end
			if (cmd.write) begin
				fill_q <= fill_inc;
				max_q  <= max_up;
			end
		end
	end

	// Captured sample and the result register.
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample_wide[DATA_WIDTH-1:0];
		end
		if (cmd.load_out) begin
			window_max_q <= max_wide[swm_pkg::SAMPLE_W-1:0];
		end
	end

	assign window_size = window_size_q;
	assign window_max  = window_max_q;

endmodule

// File: rtl/swm_ctrl.sv
// Controller of the sliding window maximum: sequences accept, eviction,
// rescan and write, and owns the handshake flags. Depends on swm_pkg.
module swm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  swm_pkg::swm_status_t  status,
	output swm_pkg::swm_cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_WRITE = 4'b1000
	} swm_state_t;

	swm_state_t state_q;
	swm_state_t state_nx;
	logic       out_valid_q;
	logic       out_blocked;

	// A result cannot be loaded while the previous one is still waiting.
	assign out_blocked = status.emit && out_valid_q && !out_ready;

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_nx = status.full ? ST_CHECK : ST_WRITE;
				end
			end
			ST_CHECK: begin
				cmd.evict = 1'b1;
				if (status.gone_is_max && !status.fill_one) begin
					state_nx = ST_SCAN;
				end else begin
					state_nx = ST_WRITE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_blocked) begin
					cmd.write    = 1'b1;
					cmd.load_out = status.emit;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
